@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl, included by the allocator
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bffa_pkg.sv @@
// package for the bitmap run allocator: sizes, request codes, result type
// no dependencies
package bffa_pkg;
    localparam int MAX_ELEMENTS = 1024;
    localparam int WORD_BITS    = 32;
    localparam int WORD_COUNT   = (MAX_ELEMENTS + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int ADDR_W       = $clog2(WORD_COUNT);
    localparam int POS_W        = IDX_W + 2;

    localparam logic [1:0] KIND_ALLOC  = 2'd0;
    localparam logic [1:0] KIND_FREE   = 2'd1;
    localparam logic [1:0] KIND_RESIZE = 2'd2;

    typedef struct packed {
        logic              ok;
        logic [IDX_W-1:0]  run_start;
        logic [CNT_W-1:0]  run_length;
        logic              moved;
    } t_result;
endpackage

@@ hw/rtl/bitmap_first_fit_run_allocator.sv @@
// bitmap first-fit run allocator: one request at a time, bit-serial over a word ram
// each element examined or changed takes a ram read, then a check or write; each walk
// phase ends in a done step and the result is then loaded into the output register; a rejected
// request skips the walk if refused on entry, and a resize that relocates runs four phases (room
// check, search, mark, free). next request taken once the result sits in the output register;
// reset clears the bitmap by a sweep over its 32 words, no request taken; element_count resets to 1024
`include "assert_macros.svh"
module bitmap_first_fit_run_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bffa_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_kind,
    input  logic [bffa_pkg::IDX_W-1:0]    i_start_index,
    input  logic [bffa_pkg::CNT_W-1:0]    i_count,
    input  logic [bffa_pkg::CNT_W-1:0]    i_new_count,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_ok,
    output logic [bffa_pkg::IDX_W-1:0]    o_run_start,
    output logic [bffa_pkg::CNT_W-1:0]    o_run_length,
    output logic                          o_moved
);
    localparam int P = bffa_pkg::POS_W;
    localparam int A = bffa_pkg::ADDR_W;
    localparam int B = bffa_pkg::BIT_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;   // issue read for r_pos
    localparam logic [3:0] S_CHK   = 4'd3;   // examine/modify bit
    localparam logic [3:0] S_DONE  = 4'd4;
    localparam logic [3:0] S_OUT   = 4'd5;

    // phase of the walk
    localparam logic [2:0] PH_FIND = 3'd0;  // first-fit search
    localparam logic [2:0] PH_SET  = 3'd1;  // mark r_pos..r_end-1 used
    localparam logic [2:0] PH_CLR  = 3'd2;  // clear r_pos..r_end-1
    localparam logic [2:0] PH_ROOM = 3'd3;  // check in-place grow room
    localparam logic [2:0] PH_FREE = 3'd4;  // free old run after a move

    logic [3:0]  r_state, n_state;
    logic [2:0]  r_ph, n_ph;
    logic [bffa_pkg::CNT_W-1:0] r_ecnt;
    logic [1:0]  r_kind, n_kind;
    logic [bffa_pkg::IDX_W-1:0] r_start, n_start;
    logic [bffa_pkg::CNT_W-1:0] r_cnt, n_cnt, r_ncnt, n_ncnt;
    logic [P-1:0] r_pos, n_pos, r_end, n_end, r_base, n_base;
    logic [P-1:0] r_len, n_len;
    logic [A-1:0] r_clr, n_clr;
    bffa_pkg::t_result r_res, n_res;
    bffa_pkg::t_result r_out, n_out;
    logic        r_ovalid, n_ovalid;

    logic          we;
    logic [A-1:0]  waddr, raddr;
    logic [bffa_pkg::WORD_BITS-1:0] wdata, rdata;
    logic [P-1:0]  limit;
    logic [B-1:0]  bsel;
    logic          used;

    bffa_ram #(.WIDTH(bffa_pkg::WORD_BITS), .DEPTH(bffa_pkg::WORD_COUNT)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign limit = (r_ecnt > bffa_pkg::CNT_W'(bffa_pkg::MAX_ELEMENTS))
        ? P'(bffa_pkg::MAX_ELEMENTS) : P'(r_ecnt);
    assign bsel  = r_pos[B-1:0];
    assign raddr = r_pos[B+A-1:B];
    assign used  = (r_pos >= limit) || rdata[bsel];

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_ok         = r_out.ok;
    assign o_run_start  = r_out.run_start;
    assign o_run_length = r_out.run_length;
    assign o_moved      = r_out.moved;

    always_comb begin
        n_state  = r_state;
        n_ph     = r_ph;
        n_kind   = r_kind;
        n_start  = r_start;
        n_cnt    = r_cnt;
        n_ncnt   = r_ncnt;
        n_pos    = r_pos;
        n_end    = r_end;
        n_base   = r_base;
        n_len    = r_len;
        n_clr    = r_clr;
        n_res    = r_res;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        we       = 1'b0;
        waddr    = r_pos[B+A-1:B];
        wdata    = rdata;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
                n_clr = r_clr + A'(1);
                if (r_clr == A'(bffa_pkg::WORD_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_kind  = i_kind;
                    n_start = i_start_index;
                    n_cnt   = i_count;
                    n_ncnt  = i_new_count;
                    n_res   = '0;
                    n_state = S_OUT;
                    unique case (i_kind)
                        bffa_pkg::KIND_ALLOC: begin
                            if (i_count != '0 && P'(i_count) <= limit) begin
                                n_state = S_RD;
                                n_ph    = PH_FIND;
                                n_pos   = '0;
                                n_base  = '0;
                                n_len   = P'(i_count);
                                n_end   = P'(i_count);
                            end
                        end
                        bffa_pkg::KIND_FREE: begin
                            n_state = S_RD;
                            n_ph    = PH_CLR;
                            n_pos   = P'(i_start_index);
                            n_end   = P'(i_start_index) + P'(i_count);
                            n_res   = '{ok: 1'b1, run_start: i_start_index,
                                        run_length: '0, moved: 1'b0};
                        end
                        bffa_pkg::KIND_RESIZE: begin
                            n_state = S_RD;
                            if (i_new_count <= i_count) begin
                                n_ph  = PH_CLR;
                                n_pos = P'(i_start_index) + P'(i_new_count);
                                n_end = P'(i_start_index) + P'(i_count);
                            end else begin
                                n_ph  = PH_ROOM;
                                n_len = P'(1);
                                n_pos = P'(i_start_index) + P'(i_count);
                                n_end = P'(i_start_index) + P'(i_new_count);
                            end
                            n_res = '{ok: 1'b1, run_start: i_start_index,
                                      run_length: i_new_count, moved: 1'b0};
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                // a candidate run that passes the end means no fit
                if (r_pos >= r_end || (r_ph == PH_FIND && r_end > limit)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = S_RD;
                n_pos   = r_pos + P'(1);
                case (r_ph)
                    PH_FIND, PH_ROOM: begin
                        if (used) begin
                            if (r_ph == PH_ROOM) begin
                                n_pos = r_end;
                                n_len = '0;   // flag: no room
                            end else begin
                                n_base = r_pos + P'(1);
                                n_end  = r_pos + P'(1) + r_len;
                            end
                        end
                    end
                    PH_SET, PH_CLR, PH_FREE: begin
                        if (r_pos < P'(bffa_pkg::MAX_ELEMENTS)) begin
                            we          = 1'b1;
                            wdata[bsel] = (r_ph == PH_SET);
                        end
                    end
                    default: ;
                endcase
            end
            S_DONE: begin
                n_state = S_RD;
                case (r_ph)
                    PH_FIND: begin
                        if (r_end > limit) begin
                            n_res   = '0;
                            n_state = S_OUT;
                        end else begin
                            n_ph  = PH_SET;
                            n_pos = r_base;
                            n_res.ok         = 1'b1;
                            n_res.run_start  = r_base[bffa_pkg::IDX_W-1:0];
                            n_res.run_length = r_len[bffa_pkg::CNT_W-1:0];
                            n_res.moved      = (r_kind == bffa_pkg::KIND_RESIZE);
                        end
                    end
                    PH_ROOM: begin
                        if (r_len == '0) begin
                            n_ph   = PH_FIND;
                            n_len  = P'(r_ncnt);
                            n_base = '0;
                            n_pos  = '0;
                            n_end  = P'(r_ncnt);
                            if (r_ncnt > limit[bffa_pkg::CNT_W-1:0]
                                || limit == '0) begin
                                n_res   = '0;
                                n_state = S_OUT;
                            end
                        end else begin
                            n_ph  = PH_SET;
                            n_pos = P'(r_start) + P'(r_cnt);
                            n_end = P'(r_start) + P'(r_ncnt);
                        end
                    end
                    PH_SET: begin
                        if (r_res.moved) begin
                            n_ph  = PH_FREE;
                            n_pos = P'(r_start);
                            n_end = P'(r_start) + P'(r_cnt);
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_ecnt   <= bffa_pkg::CNT_W'(bffa_pkg::MAX_ELEMENTS);
            r_ph     <= PH_FIND;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            r_ph     <= n_ph;
            if (i_cfg_we) begin
                r_ecnt <= i_cfg_wdata;
            end
            r_kind  <= n_kind;
            r_start <= n_start;
            r_cnt   <= n_cnt;
            r_ncnt  <= n_ncnt;
            r_pos   <= n_pos;
            r_end   <= n_end;
            r_base  <= n_base;
            r_len   <= n_len;
            r_res   <= n_res;
            r_out   <= n_out;
        end
    end

    `CHK_IMPL(a_no_take_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall, "busy but not stalling")
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, r_ovalid && i_stall, r_ovalid, "result lost under stall")
    `CHK_NEXT(a_out_stable, i_clk, i_rst_n, r_ovalid && i_stall, $stable(r_out), "result changed under stall")
    `CHK_IMPL(a_clear_no_out, i_clk, i_rst_n, r_state == S_CLEAR, !r_ovalid, "result during clear")
endmodule

@@ hw/rtl/bffa_ram.sv @@
// generic single-port-write, single-port-read synchronous ram, registered read
// no dependencies
module bffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
